@@ hw/rtl/lprl_pkg.sv @@
package lprl_pkg;

	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 6;
	localparam int IFACE_W = 3;
	localparam int TTL_W   = 8;

	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(ADDR_W);
	localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_ROUTE = 1'b1;

	typedef enum logic [2:0] {
		ST_ADDED       = 3'd0,
		ST_FULL        = 3'd1,
		ST_FORWARDED   = 3'd2,
		ST_NO_ROUTE    = 3'd3,
		ST_TTL_EXPIRED = 3'd4
	} status_t;

	typedef struct packed {
		logic               opcode;
		logic [ADDR_W-1:0]  add_prefix;
		logic [LEN_W-1:0]   prefix_len;
		logic               has_next_hop;
		logic [ADDR_W-1:0]  gateway_addr;
		logic [IFACE_W-1:0] iface_index;
		logic [ADDR_W-1:0]  dest_addr;
		logic [TTL_W-1:0]   ttl_in;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [IFACE_W-1:0] out_iface;
		logic [ADDR_W-1:0]  hop_addr;
		logic [TTL_W-1:0]   ttl_out;
	} rsp_t;

	// Write of one new route, broadcast to every cell.
	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  prefix;
		logic [LEN_W-1:0]   len;
		logic               has_gw;
		logic [ADDR_W-1:0]  gw;
		logic [IFACE_W-1:0] iface;
	} wr_t;

	// Lookup token handed from cell to cell, carrying the best match so far.
	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  dest;
		logic [TTL_W-1:0]   ttl;
		logic               found;
		logic [LEN_W-1:0]   best_len;
		logic [IFACE_W-1:0] iface;
		logic [ADDR_W-1:0]  hop;
	} tok_t;

	// Ones in the top len bits; a length of zero gives an empty mask.
	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		len_mask = ~(ADDR_ONES >> len);
	endfunction

endpackage

@@ hw/rtl/lprl_cell.sv @@
module lprl_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CNT_W-1:0]   cnt,
	input  lprl_pkg::wr_t      wr,
	input  lprl_pkg::tok_t     tok_in,
	output lprl_pkg::tok_t     tok_out
);
	import lprl_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

	logic [ADDR_W-1:0]  prefix_q;
	logic [LEN_W-1:0]   len_q;
	logic               has_gw_q;
	logic [ADDR_W-1:0]  gw_q;
	logic [IFACE_W-1:0] iface_q;

	logic valid_entry;
	logic hit;
	logic take;
	logic tok_valid_q;
	tok_t tok_q;
	tok_t tok_nxt;

	always_ff @(posedge clk) begin
		if (wr.en && cnt == MY_IDX) begin
			prefix_q <= wr.prefix;
			len_q    <= wr.len;
			has_gw_q <= wr.has_gw;
			gw_q     <= wr.gw;
			iface_q  <= wr.iface;
		end
	end

	assign valid_entry = MY_IDX < cnt;
	assign hit  = valid_entry &&
		((len_q == '0) || (prefix_q == (tok_in.dest & len_mask(len_q))));
	// Equal length still takes over, so the later route wins a tie.
	assign take = hit && (!tok_in.found || len_q >= tok_in.best_len);

	always_comb begin
		tok_nxt = tok_in;
		if (take) begin
			tok_nxt.found    = 1'b1;
			tok_nxt.best_len = len_q;
			tok_nxt.iface    = iface_q;
			tok_nxt.hop      = has_gw_q ? gw_q : tok_in.dest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

@@ hw/rtl/longest_prefix_route_lookup.sv @@
// Channel | Signals                   | Direction | Accepted when
// req     | req_valid, req_ready, req | in        | req_valid && req_ready at clk rise
// rsp     | rsp_valid, rsp_ready, rsp | out       | rsp_valid && rsp_ready at clk rise
//
// An add-route item's result passes through the pending register and then the
// output register. A route item walks the row of TABLE_DEPTH cells, one cell
// per cycle, before its result takes the same path.
// One item is in the block at a time; the next is taken as soon as the
// previous result has reached the output register, even if it waits there.
// Reset (arst_n low) empties the table and drops any item in flight.
// A stalled rsp channel holds its result and blocks further items only once
// the next result is ready behind it.
module longest_prefix_route_lookup #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lprl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lprl_pkg::rsp_t rsp
);
	import lprl_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

	// Number of stored routes; cell k is live when k is below it.
	logic [CNT_W-1:0] cnt_q;
	// Set from acceptance until the result has moved into the output register.
	logic             busy_q;
	// One result waiting to enter the output register.
	logic             pend_valid_q;
	rsp_t             pend_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic  accept;
	logic  add_acc;
	logic  full;
	logic  rsp_load;
	wr_t   wr;
	tok_t  tok_head;
	tok_t  tok [TABLE_DEPTH+1];
	tok_t  tail;
	rsp_t  add_rsp;
	rsp_t  tail_rsp;

	assign req_ready = !busy_q;
	assign accept    = req_valid && req_ready;
	assign add_acc   = accept && req.opcode == OP_ADD;
	assign full      = cnt_q == CNT_FULL;

	// Overlong prefix lengths are stored as a full-length match.
	always_comb begin
		wr.en     = add_acc && !full;
		wr.prefix = req.add_prefix;
		wr.len    = (req.prefix_len > LEN_MAX) ? LEN_MAX : req.prefix_len;
		wr.has_gw = req.has_next_hop;
		wr.gw     = req.gateway_addr;
		wr.iface  = req.iface_index;
	end

	// The lookup token enters the first cell with no match yet.
	always_comb begin
		tok_head.valid    = accept && req.opcode == OP_ROUTE;
		tok_head.dest     = req.dest_addr;
		tok_head.ttl      = req.ttl_in;
		tok_head.found    = 1'b0;
		tok_head.best_len = '0;
		tok_head.iface    = '0;
		tok_head.hop      = '0;
	end

	assign tok[0] = tok_head;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		lprl_cell #(
			.INDEX (k),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cnt     (cnt_q),
			.wr      (wr),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	assign tail = tok[TABLE_DEPTH];

	always_comb begin
		add_rsp.status    = full ? ST_FULL : ST_ADDED;
		add_rsp.out_iface = '0;
		add_rsp.hop_addr  = '0;
		add_rsp.ttl_out   = '0;
	end

	// A missing route outranks an expired TTL.
	always_comb begin
		tail_rsp.out_iface = '0;
		tail_rsp.hop_addr  = '0;
		tail_rsp.ttl_out   = '0;
		priority if (!tail.found) begin
			tail_rsp.status = ST_NO_ROUTE;
		end else if (tail.ttl <= TTL_W'(1)) begin
			tail_rsp.status = ST_TTL_EXPIRED;
		end else begin
			tail_rsp.status    = ST_FORWARDED;
			tail_rsp.out_iface = tail.iface;
			tail_rsp.hop_addr  = tail.hop;
			tail_rsp.ttl_out   = tail.ttl - TTL_W'(1);
		end
	end

	assign rsp_load = pend_valid_q && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (rsp_load) begin
				busy_q <= 1'b0;
			end
			if (add_acc || tail.valid) begin
				pend_valid_q <= 1'b1;
			end else if (rsp_load) begin
				pend_valid_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_acc) begin
			pend_q <= add_rsp;
		end else if (tail.valid) begin
			pend_q <= tail_rsp;
		end
		if (rsp_load) begin
			rsp_q <= pend_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The route count never runs past the number of cells.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("route count beyond table depth");

	// A token leaving the row always finds the pending slot free.
	a_tail_free: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> !pend_valid_q)
		else $error("lookup result arrived with a result still pending");

	// A token leaving the row finds the block still busy, so no new item is taken.
	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy_q)
		else $error("lookup in flight without the block busy");

	// A fresh result in the output register comes from an item in flight.
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(busy_q))
		else $error("result appeared with no item in flight");

endmodule
